// ===== rtl/jsqfs_pkg.sv =====
// shared types and codes for the join-shortest-queue fifo set
package jsqfs_pkg;

  localparam int NUM_Q = 3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_ILLEGAL = 2'd3
  } jsqfs_status_t;

  localparam logic       CMD_PUSH = 1'b0;
  localparam logic       CMD_POP  = 1'b1;
  localparam logic [1:0] LVL_ANY  = 2'd3;

endpackage

// ===== rtl/jsqfs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module jsqfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/join_shortest_queue_fifo_set.sv =====
// Three fifo queues sharing one ram. A push names a queue (or "any", which
// picks the queue with the fewest entries, lowest level on a tie), appends
// the item and then reports every entry of that queue front first, last one
// marked by out_tlast. A pop reports and removes the front entry. Errors
// (full queue, empty queue, pop with "any") give one result with a status
// code in out_tuser. The block takes one item at a time. A push is accepted,
// routed and written, its first ram read is issued, then results come out of
// the ram read port one per cycle while the output side does not stall. A pop
// or an error is accepted, routed (a pop reads the ram) and gives its result.
// The next item is taken once the last result sits in the output register.
module join_shortest_queue_fifo_set #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // queue_level[1:0], entry_key[17:2], entry_weight[33:18]
  input  logic        in_tuser,   // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // served_level[1:0], out_key[17:2], out_weight[33:18]
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast
);

  import jsqfs_pkg::*;

  localparam int SW = (KEY_WIDTH < 16) ? KEY_WIDTH : 16;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int RD = NUM_Q * QUEUE_DEPTH;
  localparam int AW = $clog2(RD);
  localparam int DW = SW + 16;

  typedef enum logic [1:0] {S_IDLE, S_ROUTE, S_ISSUE, S_STREAM} state_t;

  state_t        st_r, st_nxt;
  logic          cmd_r, cmd_nxt;
  logic [1:0]    lvl_r, lvl_nxt;
  logic [SW-1:0] key_r, key_nxt;
  logic [15:0]   wgt_r, wgt_nxt;
  logic [1:0]    q_r, q_nxt;
  jsqfs_status_t sts_r, sts_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [PW-1:0] head_r [NUM_Q];
  logic [PW-1:0] head_nxt [NUM_Q];
  logic [CW-1:0] fill_r [NUM_Q];
  logic [CW-1:0] fill_nxt [NUM_Q];

  logic          out_valid_r, out_valid_nxt;
  jsqfs_status_t out_sts_r, out_sts_nxt;
  logic [1:0]    out_lvl_r, out_lvl_nxt;
  logic [15:0]   out_key_r, out_key_nxt;
  logic [15:0]   out_wgt_r, out_wgt_nxt;
  logic          out_last_r, out_last_nxt;

  logic [1:0]    shortest;
  logic [1:0]    q_sel;
  logic [1:0]    a_q;
  logic [CW-1:0] a_off;
  logic [PW:0]   pos_sum;
  logic [PW-1:0] pos;
  logic [AW-1:0] ram_addr;
  logic          ram_we, ram_re;
  logic [DW-1:0] ram_rd;
  logic          out_free;
  logic          last_now;

  // fewest entries, lowest level wins a tie
  always_comb begin
    shortest = 2'd0;
    if (fill_r[1] < fill_r[0]) begin
      shortest = 2'd1;
    end
    if (fill_r[2] < fill_r[shortest]) begin
      shortest = 2'd2;
    end
  end

  always_comb begin
    if (lvl_r == LVL_ANY) begin
      q_sel = (cmd_r == CMD_PUSH) ? shortest : 2'd0;
    end else begin
      q_sel = lvl_r;
    end
  end

  // shared slot address unit: queue base plus wrapped head offset
  assign a_q      = (st_r == S_ROUTE) ? q_sel : q_r;
  assign pos_sum  = (PW + 1)'(head_r[a_q]) + (PW + 1)'(a_off);
  assign pos      = (pos_sum >= (PW + 1)'(QUEUE_DEPTH)) ?
                    PW'(pos_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(pos_sum);
  assign ram_addr = AW'(a_q) * AW'(QUEUE_DEPTH) + AW'(pos);

  assign out_free = !out_valid_r || out_tready;
  assign last_now = (CW'(i_r + 1'b1) == n_r);

  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    lvl_nxt       = lvl_r;
    key_nxt       = key_r;
    wgt_nxt       = wgt_r;
    q_nxt         = q_r;
    sts_nxt       = sts_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sts_nxt   = out_sts_r;
    out_lvl_nxt   = out_lvl_r;
    out_key_nxt   = out_key_r;
    out_wgt_nxt   = out_wgt_r;
    out_last_nxt  = out_last_r;
    a_off         = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = in_tuser;
          lvl_nxt = in_tdata[1:0];
          key_nxt = in_tdata[2 +: SW];
          wgt_nxt = in_tdata[33:18];
          st_nxt  = S_ROUTE;
        end
      end
      S_ROUTE: begin
        q_nxt = q_sel;
        n_nxt = CW'(1);
        i_nxt = '0;
        if (cmd_r == CMD_PUSH) begin
          if (fill_r[q_sel] == CW'(QUEUE_DEPTH)) begin
            // dropped item is echoed back with its own key and weight
            sts_nxt = ST_FULL;
            st_nxt  = S_STREAM;
          end else begin
            a_off           = fill_r[q_sel];
            ram_we          = 1'b1;
            fill_nxt[q_sel] = CW'(fill_r[q_sel] + 1'b1);
            n_nxt           = CW'(fill_r[q_sel] + 1'b1);
            sts_nxt         = ST_OK;
            st_nxt          = S_ISSUE;
          end
        end else if (lvl_r == LVL_ANY) begin
          sts_nxt = ST_ILLEGAL;
          key_nxt = '0;
          wgt_nxt = '0;
          st_nxt  = S_STREAM;
        end else if (fill_r[q_sel] == '0) begin
          sts_nxt = ST_EMPTY;
          key_nxt = '0;
          wgt_nxt = '0;
          st_nxt  = S_STREAM;
        end else begin
          // read the front slot at the old head, then advance it
          ram_re          = 1'b1;
          head_nxt[q_sel] = (head_r[q_sel] == PW'(QUEUE_DEPTH - 1)) ?
                            '0 : PW'(head_r[q_sel] + 1'b1);
          fill_nxt[q_sel] = CW'(fill_r[q_sel] - 1'b1);
          sts_nxt         = ST_OK;
          st_nxt          = S_STREAM;
        end
      end
      S_ISSUE: begin
        ram_re = 1'b1;
        st_nxt = S_STREAM;
      end
      S_STREAM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sts_nxt   = sts_r;
          out_lvl_nxt   = q_r;
          out_last_nxt  = last_now;
          if (sts_r == ST_OK) begin
            out_key_nxt = 16'(ram_rd[SW-1:0]);
            out_wgt_nxt = ram_rd[DW-1:SW];
          end else begin
            out_key_nxt = 16'(key_r);
            out_wgt_nxt = wgt_r;
          end
          if (last_now) begin
            st_nxt = S_IDLE;
          end else begin
            i_nxt  = CW'(i_r + 1'b1);
            a_off  = CW'(i_r + 1'b1);
            ram_re = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    lvl_r      <= lvl_nxt;
    key_r      <= key_nxt;
    wgt_r      <= wgt_nxt;
    q_r        <= q_nxt;
    sts_r      <= sts_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    out_sts_r  <= out_sts_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_key_r  <= out_key_nxt;
    out_wgt_r  <= out_wgt_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_Q; k++) begin
        head_r[k] <= '0;
        fill_r[k] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
    end
  end

  jsqfs_ram #(
    .WIDTH (DW),
    .DEPTH (RD)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_addr),
    .wr_data ({wgt_r, key_r}),
    .rd_en   (ram_re),
    .rd_addr (ram_addr),
    .rd_data (ram_rd)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_wgt_r, out_key_r, out_lvl_r};
  assign out_tuser  = out_sts_r;
  assign out_tlast  = out_last_r;

  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= CW'(QUEUE_DEPTH) && fill_r[1] <= CW'(QUEUE_DEPTH) &&
    fill_r[2] <= CW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_last_ends_item : assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_STREAM && out_free && last_now) |=> (st_r == S_IDLE))
    else $error("sequencer did not return to idle after last result");

  a_error_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sts_r != ST_OK) |-> out_last_r)
    else $error("error status result not marked last");

  a_no_ram_clash : assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("ram written and read in the same cycle");

endmodule
